### design/wu8_pkg.sv
`timescale 1ns / 1ps

package wu8_pkg;

  localparam int unsigned CpW  = 31;
  localparam int unsigned LenW = 3;

  localparam logic [15:0] SurrLo   = 16'hD800;
  localparam logic [15:0] SurrHi   = 16'hDFFF;
  // 0x10000 - 0xDC00, folded into one offset
  localparam logic [21:0] PairBias = 22'h002400;

  localparam logic [7:0] ContMark = 8'h80;
  localparam logic [7:0] Mark2    = 8'hC0;
  localparam logic [7:0] Mark3    = 8'hE0;
  localparam logic [7:0] Mark4    = 8'hF0;
  localparam logic [7:0] Mark5    = 8'hF8;
  localparam logic [7:0] Mark6    = 8'hFC;

  typedef struct packed {
    logic [CpW-1:0]  cp;
    logic [LenW-1:0] len;
  } wu8_entry_t;

  function automatic logic [LenW-1:0] enc_len(input logic [CpW-1:0] cp);
    logic [LenW-1:0] n;
    if (cp < 31'h80) begin
      n = 3'd1;
    end else if (cp < 31'h800) begin
      n = 3'd2;
    end else if (cp < 31'h10000) begin
      n = 3'd3;
    end else if (cp < 31'h200000) begin
      n = 3'd4;
    end else if (cp < 31'h4000000) begin
      n = 3'd5;
    end else begin
      n = 3'd6;
    end
    return n;
  endfunction

endpackage

### design/wu8_front.sv
`timescale 1ns / 1ps

module wu8_front import wu8_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_bit_i,
  input  logic           accept_i,
  input  logic [CpW-1:0] code_unit_i,
  output logic           emit_o,
  output wu8_entry_t     entry_o
);

  logic        pair_q, pair_d;
  logic        held_q, held_d;
  logic [10:0] lead_q, lead_d;

  logic [15:0]    unit16;
  logic           is_lead;
  logic [21:0]    combined;
  logic [CpW-1:0] cp;

  assign unit16  = code_unit_i[15:0];
  assign is_lead = (unit16 >= SurrLo) && (unit16 <= SurrHi);
  // lead - D800 is just the low eleven bits of a lead surrogate
  assign combined = {1'b0, lead_q, 10'b0} + {6'b0, unit16} + PairBias;

  always_comb begin
    held_d = held_q;
    lead_d = lead_q;
    emit_o = 1'b0;
    cp     = code_unit_i;
    pair_d = cfg_we_i ? cfg_bit_i : pair_q;
    if (accept_i) begin
      if (pair_q) begin
        if (held_q) begin
          cp     = {9'b0, combined};
          emit_o = 1'b1;
          held_d = 1'b0;
        end else if (is_lead) begin
          held_d = 1'b1;
          lead_d = unit16[10:0];
        end else begin
          cp     = {15'b0, unit16};
          emit_o = 1'b1;
        end
      end else begin
        emit_o = 1'b1;
        held_d = 1'b0;
      end
    end
  end

  assign entry_o.cp  = cp;
  assign entry_o.len = enc_len(cp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q <= 1'b1;
      held_q <= 1'b0;
    end else begin
      pair_q <= pair_d;
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lead_q <= lead_d;
  end

endmodule

### design/wu8_fifo.sv
`timescale 1ns / 1ps

module wu8_fifo import wu8_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_i,
  input  wu8_entry_t wdata_i,
  input  logic       rd_i,
  output wu8_entry_t rdata_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  wu8_entry_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### design/wu8_back.sv
`timescale 1ns / 1ps

module wu8_back import wu8_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  wu8_entry_t head_i,
  input  logic       head_valid_i,
  output logic       head_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_byte_o,
  output logic [2:0] byte_index_o,
  output logic       last_byte_o
);

  logic       valid_q, valid_d;
  logic [2:0] idx_q, idx_d;
  logic [7:0] byte_q;
  logic [2:0] index_q;
  logic       last_q;

  logic       advance;
  logic       is_last;
  logic [2:0] sel;
  logic [5:0] group;
  logic [7:0] cur_byte;

  assign advance = head_valid_i && (!valid_q || pop_i);
  assign is_last = (idx_q == head_i.len - 3'd1);
  // six-bit group that this continuation byte carries
  assign sel     = head_i.len - 3'd1 - idx_q;

  always_comb begin
    case (sel)
      3'd0:    group = head_i.cp[5:0];
      3'd1:    group = head_i.cp[11:6];
      3'd2:    group = head_i.cp[17:12];
      3'd3:    group = head_i.cp[23:18];
      3'd4:    group = head_i.cp[29:24];
      default: group = {5'b0, head_i.cp[30]};
    endcase
  end

  always_comb begin
    if (idx_q == 3'd0) begin
      case (head_i.len)
        3'd1:    cur_byte = {1'b0, head_i.cp[6:0]};
        3'd2:    cur_byte = Mark2 | {3'b0, head_i.cp[10:6]};
        3'd3:    cur_byte = Mark3 | {4'b0, head_i.cp[15:12]};
        3'd4:    cur_byte = Mark4 | {5'b0, head_i.cp[20:18]};
        3'd5:    cur_byte = Mark5 | {6'b0, head_i.cp[25:24]};
        default: cur_byte = Mark6 | {7'b0, head_i.cp[30]};
      endcase
    end else begin
      cur_byte = ContMark | {2'b0, group};
    end
  end

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (advance) begin
      valid_d = 1'b1;
      idx_d   = is_last ? 3'd0 : idx_q + 3'd1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  assign head_pop_o   = advance && is_last;
  assign empty_o      = !valid_q;
  assign out_byte_o   = byte_q;
  assign byte_index_o = index_q;
  assign last_byte_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 3'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q  <= cur_byte;
      index_q <= idx_q;
      last_q  <= is_last;
    end
  end

endmodule

### design/wide_unit_to_utf8_encoder.sv
// a unit that makes bytes passes the queue, then the serialiser's byte register, before its first byte shows
// throughput: one byte per cycle out of the byte serialiser while pop_i is high and the queue is not empty;
// a unit gives 1 to 6 bytes (its utf-8 length); a held lead surrogate produces nothing
// a queue of FifoDepth code points sits between the classifier and the serialiser
// reset (rst_ni low, asynchronous): queue and output empty, no lead held, pairing enabled
`timescale 1ns / 1ps

module wide_unit_to_utf8_encoder import wu8_pkg::*; #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_data_i,
  input  logic           push_i,
  output logic           full_o,
  input  logic [CpW-1:0] code_unit_i,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [7:0]     out_byte_o,
  output logic [2:0]     byte_index_o,
  output logic           last_byte_o
);

  logic       accept;
  logic       emit;
  wu8_entry_t entry;
  wu8_entry_t head;
  logic       q_full, q_empty, q_pop;

  assign cfg_ready_o = 1'b1;
  assign full_o      = q_full;
  assign accept      = push_i && !q_full;

  wu8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_bit_i   (cfg_data_i),
    .accept_i    (accept),
    .code_unit_i (code_unit_i),
    .emit_o      (emit),
    .entry_o     (entry)
  );

  wu8_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (emit),
    .wdata_i (entry),
    .rd_i    (q_pop),
    .rdata_o (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  wu8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!q_empty),
    .head_pop_o   (q_pop),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .out_byte_o   (out_byte_o),
    .byte_index_o (byte_index_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

### test/tb_wide_unit_to_utf8_encoder.sv
`timescale 1ns / 1ps

module tb_wide_unit_to_utf8_encoder;
  import wu8_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic [2:0] index;
    logic       last;
  } utf8_byte_t;

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_valid_i;
  logic           cfg_ready_o;
  logic           cfg_data_i;
  logic           push_i;
  logic           full_o;
  logic [CpW-1:0] code_unit_i;
  logic           pop_i;
  logic           empty_o;
  logic [7:0]     out_byte_o;
  logic [2:0]     byte_index_o;
  logic           last_byte_o;

  wide_unit_to_utf8_encoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .push_i       (push_i),
    .full_o       (full_o),
    .code_unit_i  (code_unit_i),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .out_byte_o   (out_byte_o),
    .byte_index_o (byte_index_o),
    .last_byte_o  (last_byte_o)
  );

  // predictor state, mirrors the block after reset
  logic        pairing_on   = 1'b1;
  logic        lead_waiting = 1'b0;
  logic [15:0] held_lead    = 16'h0;

  utf8_byte_t  expected_bytes[$];
  utf8_byte_t  want;
  int          errors      = 0;
  int          units_sent  = 0;
  int          burst_left  = 0;
  int          gap_max     = 0;
  int          burst_max   = 8;
  int          stall_pct   = 0;
  int          stall_max   = 1;
  int          stall_left  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("wide_unit_to_utf8_encoder: mismatch");
    $finish;
  end

  // expected byte sequence of one code point
  task automatic queue_utf8(input logic [CpW-1:0] cp);
    int         n;
    logic [7:0] mark;
    logic [7:0] mask;
    logic [CpW-1:0] part;
    utf8_byte_t b;
    if (cp < 31'h80) begin
      n = 1; mark = 8'h00; mask = 8'h7F;
    end else if (cp < 31'h800) begin
      n = 2; mark = Mark2; mask = 8'h1F;
    end else if (cp < 31'h10000) begin
      n = 3; mark = Mark3; mask = 8'h0F;
    end else if (cp < 31'h200000) begin
      n = 4; mark = Mark4; mask = 8'h07;
    end else if (cp < 31'h4000000) begin
      n = 5; mark = Mark5; mask = 8'h03;
    end else begin
      n = 6; mark = Mark6; mask = 8'h01;
    end
    for (int k = 0; k < n; k++) begin
      part = cp >> (6 * (n - 1 - k));
      if (k == 0) b.value = mark | (part[7:0] & mask);
      else b.value = ContMark | {2'b00, part[5:0]};
      b.index = 3'(k);
      b.last  = (k == n - 1);
      expected_bytes.push_back(b);
    end
  endtask

  task automatic predict_unit(input logic [CpW-1:0] unit);
    logic [31:0] cp;
    logic [15:0] low;
    if (pairing_on) begin
      low = unit[15:0];
      if (lead_waiting) begin
        // second unit is taken as a trail whatever it holds
        cp = 32'h10000 + ((32'(held_lead) - 32'hD800) << 10) + 32'(low) - 32'hDC00;
        lead_waiting = 1'b0;
        held_lead    = 16'h0;
        queue_utf8(cp[CpW-1:0]);
      end else if (low >= 16'hD800 && low < 16'hE000) begin
        held_lead    = low;
        lead_waiting = 1'b1;
      end else begin
        queue_utf8({15'b0, low});
      end
    end else begin
      lead_waiting = 1'b0;
      held_lead    = 16'h0;
      queue_utf8(unit);
    end
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_unit(input logic [CpW-1:0] unit);
    push_i      <= 1'b1;
    code_unit_i <= unit;
    do @(posedge clk_i); while (full_o);
    predict_unit(unit);
    units_sent++;
    @(negedge clk_i);
  endtask

  // bursts with random gaps between them
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, burst_max);
      if (gap_max > 0) begin
        push_i <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk_i);
      end
    end
  endtask

  task automatic drain_results();
    push_i <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk_i);
    // a lone lead gives no byte, so allow it to settle
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_pairing(input logic on);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= on;
    do @(posedge clk_i); while (!cfg_ready_o);
    pairing_on = on;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CpW-1:0] wide_random();
    case ($urandom_range(0, 6))
      0: return CpW'($urandom_range(0, 32'h7F));
      1: return CpW'($urandom_range(32'h80, 32'h7FF));
      2: return CpW'($urandom_range(32'h800, 32'hFFFF));
      3: return CpW'($urandom_range(32'h10000, 32'h1FFFFF));
      4: return CpW'($urandom_range(32'h200000, 32'h3FFFFFF));
      5: return CpW'($urandom_range(32'h4000000, 32'h7FFFFFFF));
      default: return CpW'($urandom);
    endcase
  endfunction

  // mostly well-formed 16-bit text, some lone or broken surrogates
  task automatic send_random_16();
    logic [15:0] low;
    logic [15:0] trail;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      low = 16'(wide_random() % 31'h10000);
      if (low >= 16'hD800 && low < 16'hE000) low = low - 16'h1000;
    end else if (pick < 75) begin
      low   = 16'($urandom_range(16'hD800, 16'hDBFF));
      trail = 16'($urandom_range(16'hDC00, 16'hDFFF));
      send_unit({($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'b0, low});
      pace();
      low = trail;
    end else begin
      low = 16'($urandom);
    end
    send_unit({($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'b0, low});
    pace();
  endtask

  initial begin
    pop_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        pop_i <= 1'b0;
        stall_left--;
      end else begin
        pop_i <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, stall_max);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) begin
      if (expected_bytes.size() == 0) begin
        $error("byte %02h with nothing expected", out_byte_o);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte_o !== want.value) begin
          $error("out_byte: expected %02h, got %02h", want.value, out_byte_o);
          errors++;
        end
        if (byte_index_o !== want.index) begin
          $error("byte_index: expected %0d, got %0d", want.index, byte_index_o);
          errors++;
        end
        if (last_byte_o !== want.last) begin
          $error("last_byte: expected %0b, got %0b", want.last, last_byte_o);
          errors++;
        end
      end
    end
  end

  // pairing on from reset: boundaries, pairs, broken pairs, ignored high bits
  task automatic test_bmp_units();
    logic [CpW-1:0] units[$] = '{31'h0, 31'h7F, 31'h80, 31'h7FF, 31'h800, 31'hD7FF,
                                 31'hE000, 31'hFFFF, 31'h7FFF0041,
                                 31'hD800, 31'hDC00, 31'hDBFF, 31'hDFFF,
                                 31'h1234D900, 31'h5A5A0041, 31'hDBFF, 31'hD800};
    stall_pct = 30;
    stall_max = 4;
    foreach (units[i]) send_unit(units[i]);
  endtask

  task automatic test_full_code_points();
    logic [CpW-1:0] units[$] = '{31'h10000, 31'h1FFFFF, 31'h200000, 31'h3FFFFFF,
                                 31'h4000000, 31'h7FFFFFFF, 31'hD800,
                                 31'h55555555, 31'h2AAAAAAA};
    write_pairing(1'b0);
    foreach (units[i]) send_unit(units[i]);
  endtask

  // a held lead survives a register write but not a unit in full mode
  task automatic test_mode_switch();
    write_pairing(1'b1);
    send_unit(31'hD801);
    write_pairing(1'b1);
    send_unit(31'hDC05);
    send_unit(31'hD801);
    write_pairing(1'b0);
    send_unit(31'h41);
    write_pairing(1'b1);
    send_unit(31'h42);
  endtask

  task automatic test_random_traffic();
    int target;
    gap_max   = 6;
    burst_max = 10;
    stall_pct = 25;
    stall_max = 8;
    target = units_sent + 80;
    while (units_sent < target) send_random_16();

    write_pairing(1'b0);
    target = units_sent + 80;
    while (units_sent < target) begin
      send_unit(wide_random());
      pace();
      if (units_sent == target - 40) drain_results();
    end

    // back to back with no stall at either side
    write_pairing(1'b1);
    gap_max   = 0;
    stall_pct = 0;
    target = units_sent + 50;
    while (units_sent < target) send_random_16();

    write_pairing(1'b0);
    gap_max   = 3;
    burst_max = 4;
    stall_pct = 60;
    stall_max = 3;
    target = units_sent + 60;
    while (units_sent < target) begin
      send_unit(wide_random());
      pace();
    end
  endtask

  initial begin
    int waited;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
    push_i      = 1'b0;
    code_unit_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_bmp_units();
    test_full_code_points();
    test_mode_switch();
    test_random_traffic();

    push_i <= 1'b0;
    waited = 0;
    while (expected_bytes.size() != 0 && waited < 100000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (20) @(negedge clk_i);
    if (expected_bytes.size() != 0) begin
      $error("%0d bytes never arrived", expected_bytes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("wide_unit_to_utf8_encoder: match");
    end else begin
      $display("wide_unit_to_utf8_encoder: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
design/wu8_pkg.sv
design/wu8_front.sv
design/wu8_fifo.sv
design/wu8_back.sv
design/wide_unit_to_utf8_encoder.sv
test/tb_wide_unit_to_utf8_encoder.sv
